// ----- design/frp_pkg.sv -----
// flux interval resampler: shared types and constants
// no dependencies; imported by the front, queue and back modules
package frp_pkg;

    // configuration register indexes
    localparam logic CFG_DRIVE_TIME = 1'b0;
    localparam logic CFG_IMAGE_TIME = 1'b1;

    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned SAMPLE_W    = 16;
    localparam int unsigned TICKS_W     = 17;
    localparam int unsigned ADD_W       = TICKS_W + CFG_DATA_W;
    localparam int unsigned ACC_W       = 64;
    localparam int unsigned ZEROS_W     = ACC_W - SAMPLE_W;

    localparam logic [CFG_DATA_W-1:0] TIME_RESET = 32'd8000000;
    localparam logic [TICKS_W-1:0]    FULL_TICKS = 17'h10000;

    // job queue depth
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_IDX_W = 1;
    localparam int unsigned QUEUE_CNT_W = 2;

    // one classified sample handed from front to back
    typedef struct packed {
        logic [ADD_W-1:0] add;   // ticks times drive_time
        logic             cont;  // zero sample that carries into the next one
    } t_job;

endpackage

// ----- design/frp_in_if.sv -----
// input channel of the flux interval resampler: valid/ready and one sample
// no dependencies
interface frp_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] flux_sample;
    logic        last_sample;

    modport source (output valid, output flux_sample, output last_sample, input ready);
    modport sink   (input valid, input flux_sample, input last_sample, output ready);
endinterface

// ----- design/frp_out_if.sv -----
// output channel of the flux interval resampler: valid/ready and one result
// no dependencies
interface frp_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_sample;
    logic        last_of_run;
    logic        run_overflow;

    modport source (output valid, output out_sample, output last_of_run,
                    output run_overflow, input ready);
    modport sink   (input valid, input out_sample, input last_of_run,
                    input run_overflow, output ready);
endinterface

// ----- design/frp_front.sv -----
// front end: configuration registers, sample classification and scaling multiply
// depends on frp_pkg and frp_in_if
module frp_front
    import frp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    frp_in_if.sink                i_flux,
    input  logic                  i_q_full,
    output logic                  o_push,
    output t_job                  o_job,
    output logic [CFG_DATA_W-1:0] o_image_time
);

    logic [CFG_DATA_W-1:0] r_drive_time;
    logic [CFG_DATA_W-1:0] r_image_time;
    logic [TICKS_W-1:0]    ticks;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive_time <= TIME_RESET;
            r_image_time <= TIME_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DRIVE_TIME: r_drive_time <= i_cfg_data;
                CFG_IMAGE_TIME: r_image_time <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // a zero sample stands for a full 65536-tick interval
    assign ticks = (i_flux.flux_sample == '0) ? FULL_TICKS
                                              : {1'b0, i_flux.flux_sample};

    // accept whenever the queue has room
    assign i_flux.ready = !i_q_full;
    assign o_push       = i_flux.valid && !i_q_full;

    // scale to drive ticks; the queue entry registers the product
    assign o_job.add  = ADD_W'(ticks) * ADD_W'(r_drive_time);
    assign o_job.cont = (i_flux.flux_sample == '0) && !i_flux.last_sample;

    assign o_image_time = r_image_time;

endmodule

// ----- design/frp_queue.sv -----
// short job queue between front and back
// depends on frp_pkg
module frp_queue
    import frp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    t_job                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_IDX_W-1:0] r_wr;
    logic [QUEUE_IDX_W-1:0] r_rd;
    logic [QUEUE_CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- design/frp_back.sv -----
// back end: saturating accumulate, bit-serial 64/32 division and run emission
// depends on frp_pkg and frp_out_if
module frp_back
    import frp_pkg::*;
#(
    parameter int unsigned MAX_RUN = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [CFG_DATA_W-1:0] i_image_time,
    input  logic                  i_q_empty,
    input  t_job                  i_job,
    output logic                  o_pop,
    frp_out_if.source             o_res
);

    localparam int unsigned CW = $clog2(MAX_RUN);
    localparam logic [CW-1:0]      LIMIT_C  = CW'(MAX_RUN - 1);
    localparam logic [ZEROS_W-1:0] LIMIT_WD = ZEROS_W'(MAX_RUN - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ADD  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_POST = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]            r_state;
    logic [ACC_W-1:0]      r_acc;
    logic [ADD_W-1:0]      r_add;
    logic                  r_cont;
    logic [ACC_W-1:0]      r_quo;
    logic [CFG_DATA_W-1:0] r_rem;
    logic [5:0]            r_step;
    logic [CW-1:0]         r_zcnt;
    logic [SAMPLE_W-1:0]   r_final;
    logic                  r_cut;

    logic [ACC_W:0]        sum;
    logic [ACC_W-1:0]      sat_sum;
    logic [CFG_DATA_W-1:0] divisor;
    logic [CFG_DATA_W:0]   rem_sh;
    logic [CFG_DATA_W:0]   rem_sub;
    logic                  q_bit;
    logic [ZEROS_W-1:0]    zeros;
    logic                  emit_done;

    // saturating accumulate
    assign sum     = {1'b0, r_acc} + (ACC_W + 1)'(r_add);
    assign sat_sum = sum[ACC_W] ? '1 : sum[ACC_W-1:0];

    // one restoring division step
    assign divisor = (i_image_time == '0) ? CFG_DATA_W'(1) : i_image_time;
    assign rem_sh  = {r_rem, r_quo[ACC_W-1]};
    assign rem_sub = rem_sh - {1'b0, divisor};
    assign q_bit   = !rem_sub[CFG_DATA_W];

    assign zeros = r_quo[ACC_W-1:SAMPLE_W];

    // result port driven from registers
    assign o_res.valid        = (r_state == ST_EMIT);
    assign o_res.last_of_run  = (r_zcnt == '0);
    assign o_res.out_sample   = (r_zcnt == '0) ? r_final : '0;
    assign o_res.run_overflow = r_cut;
    assign emit_done = o_res.valid && o_res.ready && (r_zcnt == '0);

    assign o_pop = (r_state == ST_IDLE) && !i_q_empty;

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_acc   <= '0;
            r_zcnt  <= '0;
            r_step  <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (!i_q_empty) begin
                        r_state <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    if (r_cont) begin
                        r_acc   <= sat_sum;
                        r_state <= ST_IDLE;
                    end else begin
                        r_step  <= '1;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_step <= r_step - 1'b1;
                    if (r_step == '0) begin
                        r_state <= ST_POST;
                    end
                end
                ST_POST: begin
                    r_acc   <= {{(ACC_W - CFG_DATA_W){1'b0}}, r_rem};
                    r_zcnt  <= (zeros > LIMIT_WD) ? LIMIT_C : zeros[CW-1:0];
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (emit_done) begin
                        r_state <= ST_IDLE;
                    end else if (o_res.valid && o_res.ready) begin
                        r_zcnt <= r_zcnt - 1'b1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_add  <= i_job.add;
            r_cont <= i_job.cont;
        end
        if (r_state == ST_ADD) begin
            r_quo <= sat_sum;
            r_rem <= '0;
        end else if (r_state == ST_DIV) begin
            r_quo <= {r_quo[ACC_W-2:0], q_bit};
            r_rem <= q_bit ? rem_sub[CFG_DATA_W-1:0] : rem_sh[CFG_DATA_W-1:0];
        end
        if (r_state == ST_POST) begin
            r_final <= (r_quo[SAMPLE_W-1:0] == '0) ? SAMPLE_W'(1) : r_quo[SAMPLE_W-1:0];
            r_cut   <= (zeros > LIMIT_WD);
        end
    end

endmodule

// ----- design/flux_interval_resampler_unit.sv -----
// An ending sample passes through the queue, the add state, 64 division steps in a
// divider that makes one quotient bit per cycle, and a post step before its first result;
// a continued zero sample is only added to the accumulator. The back end takes no new
// sample until every result of the last one has been accepted; the front takes samples
// while the two-entry queue has room. Synchronous active-low reset clears the accumulator,
// the queue and all control state, and loads both rotation times with 8000000.
module flux_interval_resampler_unit
    import frp_pkg::*;
#(
    parameter int unsigned MAX_RUN = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    frp_in_if.sink                i_flux,
    frp_out_if.source             o_res
);

    logic                  push;
    logic                  pop;
    logic                  q_full;
    logic                  q_empty;
    t_job                  job_in;
    t_job                  job_out;
    logic [CFG_DATA_W-1:0] image_time;

    // classify and scale incoming samples
    frp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_flux       (i_flux),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_job        (job_in),
        .o_image_time (image_time)
    );

    // decoupling queue
    frp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_job   (job_out),
        .o_empty (q_empty)
    );

    // accumulate, divide and emit
    frp_back #(
        .MAX_RUN (MAX_RUN)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_image_time (image_time),
        .i_q_empty    (q_empty),
        .i_job        (job_out),
        .o_pop        (pop),
        .o_res        (o_res)
    );

endmodule

// ----- design/frp_checker.sv -----
// port-level checks for the flux interval resampler
// depends on flux_interval_resampler_unit, which it is bound to
module frp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [15:0] i_out_sample,
    input logic        i_last_of_run,
    input logic        i_run_overflow
);

    // a stalled result transaction holds its payload
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_out_sample)
            && $stable(i_last_of_run) && $stable(i_run_overflow))
        else $error("result changed while stalled");

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

    // zero markers are never the final result, the final result is never zero
    a_marker_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ((i_out_sample == 16'd0) != i_last_of_run))
        else $error("zero marker and final flag disagree");

    // a run continues without gaps and keeps its overflow flag
    a_run_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready && !i_last_of_run |=>
            i_valid && (i_run_overflow == $past(i_run_overflow)))
        else $error("run broken or overflow flag changed");

endmodule

bind flux_interval_resampler_unit frp_checker u_frp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_res.valid),
    .i_ready        (o_res.ready),
    .i_out_sample   (o_res.out_sample),
    .i_last_of_run  (o_res.last_of_run),
    .i_run_overflow (o_res.run_overflow)
);
